@@ hw/rtl/ncm_pkg.sv @@
// ----------------------------------------------------------------------------
// Normalization cube map package
// Shared widths, face codes, search state and helpers for the texel pipeline.
// ----------------------------------------------------------------------------
package ncm_pkg;

    // Texels along one face edge
    localparam int FACE_SIZE = 32;

    // Field widths
    localparam int FACE_W  = 3;
    localparam int COL_W   = 5;
    localparam int ROW_W   = 5;
    localparam int CH_W    = 8;

    // Direction vector arithmetic, in half-texel units
    localparam int COORD_W = $clog2(FACE_SIZE + 64) + 1;
    localparam int MAG_W   = COORD_W - 1;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int N_W     = SQ_W + 2;
    localparam int DSQ_W   = 2 * CH_W;
    localparam int RHS_W   = DSQ_W + SQ_W;
    localparam int LHS_W   = DSQ_W + N_W;

    // 255 squared
    localparam logic [DSQ_W-1:0] PACK_SQ = DSQ_W'((2**CH_W - 1) * (2**CH_W - 1));

    // Face codes
    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

    typedef logic signed [COORD_W-1:0] coord_t;

    // State of the per-channel byte search carried down the pipeline
    typedef struct packed {
        logic                      bad;    // face code names no face
        logic [2:0]                neg;    // component sign
        logic [N_W-1:0]            n;      // squared vector length
        logic [2:0][RHS_W-1:0]     rhs;    // 255^2 * c^2
        logic [2:0][CH_W-1:0]      k;      // byte found so far
        logic [CH_W-1:0]           probe;  // bit under test
    } srch_t;

    // |2*cand - 255| for a byte candidate; always odd
    function automatic logic [CH_W-1:0] dist_mag(input logic [CH_W-1:0] cand);
        dist_mag = {cand[CH_W-1] ? cand[CH_W-2:0] : ~cand[CH_W-2:0], 1'b1};
    endfunction

endpackage

@@ hw/rtl/ncm_front.sv @@
// ----------------------------------------------------------------------------
// Normalization cube map front end
// Face decode, component squares, length and right-hand sides: three stages.
// ----------------------------------------------------------------------------
module ncm_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [ncm_pkg::FACE_W-1:0] face,
    input  logic [ncm_pkg::COL_W-1:0]  col,
    input  logic [ncm_pkg::ROW_W-1:0]  row,
    output logic                     out_valid,
    input  logic                     out_ready,
    output ncm_pkg::srch_t           out_st
);
    import ncm_pkg::*;

    logic             v1_reg, v2_reg, v3_reg;
    logic             en1, en2, en3;

    coord_t           vec_reg  [3];
    coord_t           vec_next [3];
    logic             bad1_reg, bad1_next;

    logic [SQ_W-1:0]  sq_reg  [3];
    logic [SQ_W-1:0]  sq_next [3];
    logic [2:0]       neg2_reg, neg2_next;
    logic             bad2_reg;

    srch_t            st_reg, st_next;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // Stage 1: face vector
    always_comb begin
        coord_t h, a, b;
        h = coord_t'(FACE_SIZE);
        a = coord_t'({col, 1'b1}) - h;
        b = coord_t'({row, 1'b1}) - h;
        bad1_next = 1'b0;
        unique case (face)
            FACE_POS_X: begin
                vec_next[0] = h;  vec_next[1] = -b; vec_next[2] = -a;
            end
            FACE_NEG_X: begin
                vec_next[0] = -h; vec_next[1] = -b; vec_next[2] = a;
            end
            FACE_POS_Y: begin
                vec_next[0] = a;  vec_next[1] = h;  vec_next[2] = b;
            end
            FACE_NEG_Y: begin
                vec_next[0] = a;  vec_next[1] = -h; vec_next[2] = -b;
            end
            FACE_POS_Z: begin
                vec_next[0] = a;  vec_next[1] = -b; vec_next[2] = h;
            end
            FACE_NEG_Z: begin
                vec_next[0] = -a; vec_next[1] = -b; vec_next[2] = -h;
            end
            default: begin
                vec_next[0] = '0; vec_next[1] = '0; vec_next[2] = '0;
                bad1_next   = 1'b1;
            end
        endcase
    end

    // Stage 2: sign and square of each component
    always_comb begin
        coord_t           m;
        logic [MAG_W-1:0] mag;
        for (int i = 0; i < 3; i++) begin
            neg2_next[i] = vec_reg[i][COORD_W-1];
            m            = neg2_next[i] ? -vec_reg[i] : vec_reg[i];
            mag          = m[MAG_W-1:0];
            sq_next[i]   = SQ_W'(mag) * SQ_W'(mag);
        end
    end

    // Stage 3: squared length and scaled squares
    always_comb begin
        st_next       = '0;
        st_next.bad   = bad2_reg;
        st_next.neg   = neg2_reg;
        st_next.n     = N_W'(sq_reg[0]) + N_W'(sq_reg[1]) + N_W'(sq_reg[2]);
        for (int i = 0; i < 3; i++) begin
            st_next.rhs[i] = RHS_W'(PACK_SQ) * RHS_W'(sq_reg[i]);
        end
        st_next.probe = {1'b1, {(CH_W-1){1'b0}}};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            vec_reg  <= vec_next;
            bad1_reg <= bad1_next;
        end
        if (en2) begin
            sq_reg   <= sq_next;
            neg2_reg <= neg2_next;
            bad2_reg <= bad1_reg;
        end
        if (en3) begin
            st_reg   <= st_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_st    = st_reg;

endmodule

@@ hw/rtl/ncm_search_step.sv @@
// ----------------------------------------------------------------------------
// Normalization cube map search step
// Decides one bit of each packed channel byte by an exact squared compare.
// ----------------------------------------------------------------------------
module ncm_search_step (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  ncm_pkg::srch_t in_st,
    output logic           out_valid,
    input  logic           out_ready,
    output ncm_pkg::srch_t out_st
);
    import ncm_pkg::*;

    logic              a_vld_reg, b_vld_reg;
    logic              en_a, en_b;
    srch_t             a_st_reg;
    logic [DSQ_W-1:0]  a_dsq_reg  [3];
    logic [DSQ_W-1:0]  dsq_next   [3];
    srch_t             b_st_reg, b_st_next;

    assign en_b     = !b_vld_reg || out_ready;
    assign en_a     = !a_vld_reg || en_b;
    assign in_ready = en_a;

    // Stage A: (2*cand - 255)^2 for the candidate byte
    always_comb begin
        logic [CH_W-1:0] cand, dm;
        for (int i = 0; i < 3; i++) begin
            cand        = in_st.k[i] | in_st.probe;
            dm          = dist_mag(cand);
            dsq_next[i] = DSQ_W'(dm) * DSQ_W'(dm);
        end
    end

    // Stage B: keep the bit when (2*cand - 255) * L <= 255 * c
    always_comb begin
        logic [CH_W-1:0]  cand;
        logic [LHS_W-1:0] lhs, rhs;
        logic             hit;
        b_st_next       = a_st_reg;
        b_st_next.probe = a_st_reg.probe >> 1;
        for (int i = 0; i < 3; i++) begin
            cand = a_st_reg.k[i] | a_st_reg.probe;
            lhs  = LHS_W'(a_dsq_reg[i]) * LHS_W'(a_st_reg.n);
            rhs  = LHS_W'(a_st_reg.rhs[i]);
            if (cand[CH_W-1]) begin
                hit = !a_st_reg.neg[i] && (lhs <= rhs);
            end else begin
                hit = !a_st_reg.neg[i] || (lhs >= rhs);
            end
            if (hit) begin
                b_st_next.k[i] = cand;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end else begin
            if (en_a) a_vld_reg <= in_valid;
            if (en_b) b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            a_st_reg  <= in_st;
            a_dsq_reg <= dsq_next;
        end
        if (en_b) begin
            b_st_reg  <= b_st_next;
        end
    end

    assign out_valid = b_vld_reg;
    assign out_st    = b_st_reg;

endmodule

@@ hw/rtl/normalization_cube_map_texel.sv @@
// ----------------------------------------------------------------------------
// Normalization cube map texel generator
// Takes a cube face and texel position and returns the packed unit direction.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one texel request per beat: face code, column
//   and row. Output stream m_axis returns one RGB texel per request, in
//   order, each channel floor((c / |v| * 0.5 + 0.5) * 255), exact.
//   A face code of 6 or 7 returns an all-zero texel.
//   From acceptance to m_axis_tvalid a request passes three stages of
//   face decode, squaring and length, then two stages for each of the eight
//   byte bits, found MSB first by a squared-length compare per channel.
//   Throughput is one texel per cycle while m_axis_tready is high; the length
//   multiply in each search step sets the stage depth.
//   Each stage has its own valid bit and advances when it is empty or the
//   stage after it advances, so a stall on m_axis_tready fills bubbles first
//   and then holds everything; no request is lost or repeated.
//   Synchronous reset (aresetn low) empties the pipeline; there is no other
//   state.
// ----------------------------------------------------------------------------
module normalization_cube_map_texel (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // face[2:0], col[7:3], row[12:8], zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // red[7:0], green[15:8], blue[23:16]
);
    import ncm_pkg::*;

    localparam int STEPS = CH_W;

    logic  vld   [STEPS+1];
    logic  rdy   [STEPS+1];
    srch_t st    [STEPS+1];
    srch_t last_st;

    ncm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .face      (s_axis_tdata[FACE_W-1:0]),
        .col       (s_axis_tdata[FACE_W+COL_W-1:FACE_W]),
        .row       (s_axis_tdata[FACE_W+COL_W+ROW_W-1:FACE_W+COL_W]),
        .out_valid (vld[0]),
        .out_ready (rdy[0]),
        .out_st    (st[0])
    );

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        ncm_search_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (vld[g]),
            .in_ready  (rdy[g]),
            .in_st     (st[g]),
            .out_valid (vld[g+1]),
            .out_ready (rdy[g+1]),
            .out_st    (st[g+1])
        );
    end

    assign rdy[STEPS]    = m_axis_tready;
    assign last_st       = st[STEPS];
    assign m_axis_tvalid = vld[STEPS];
    assign m_axis_tdata  = last_st.bad ? '0 : {last_st.k[2], last_st.k[1], last_st.k[0]};

`ifndef SYNTHESIS
    // A ready sink must never stall the input side
    a_sink_ready_passes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is ready");

    // An empty output stage means every stage can advance
    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    // Reset empties the pipeline
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");
`endif

endmodule

@@ tb/sv/ncm_texel_checker.sv @@
// ----------------------------------------------------------------------------
// Normalization cube map texel checker
// Watches both streams. For every accepted request it works out the exact
// packed unit direction and compares it with the next returned texel.
// ----------------------------------------------------------------------------
module ncm_texel_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // face[2:0], col[7:3], row[12:8], zero
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    output int          fail_count,
    output int          texels_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ncm_pkg::*;

    typedef struct {
        logic [FACE_W-1:0] face;
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
    } texel_t;

    texel_t expected_texels[$];
    int     errors = 0;

    assign fail_count     = errors;
    assign texels_pending = expected_texels.size();

    // d * sqrt(n) <= 255 * c, with d = 2k - 255, done on squares
    function automatic bit byte_fits(input longint d, input longint c, input longint n);
        longint dm;
        longint cm;
        longint lhs;
        longint rhs;
        dm  = (d < 0) ? -d : d;
        cm  = (c < 0) ? -c : c;
        lhs = dm * dm * n;
        rhs = 65025 * cm * cm;
        if (d >= 0)
            return (c >= 0) && (lhs <= rhs);
        if (c >= 0)
            return 1'b1;
        return lhs >= rhs;
    endfunction

    // floor(255 * (c + L) / (2L)), L = sqrt(n)
    function automatic logic [CH_W-1:0] pack_channel(input longint c, input longint n);
        for (int k = 255; k > 0; k--) begin
            if (byte_fits(2 * k - 255, c, n))
                return CH_W'(k);
        end
        return '0;
    endfunction

    function automatic texel_t predict_texel(input logic [FACE_W-1:0] face,
                                             input logic [COL_W-1:0]  col,
                                             input logic [ROW_W-1:0]  row);
        texel_t t;
        longint a;
        longint b;
        longint h;
        longint vx;
        longint vy;
        longint vz;
        longint n;
        bit     valid_face;
        a  = 2 * longint'(col) + 1 - FACE_SIZE;
        b  = 2 * longint'(row) + 1 - FACE_SIZE;
        h  = FACE_SIZE;
        vx = 0;
        vy = 0;
        vz = 0;
        valid_face = 1'b1;
        case (face)
            FACE_POS_X: begin vx = h;  vy = -b; vz = -a; end
            FACE_NEG_X: begin vx = -h; vy = -b; vz = a;  end
            FACE_POS_Y: begin vx = a;  vy = h;  vz = b;  end
            FACE_NEG_Y: begin vx = a;  vy = -h; vz = -b; end
            FACE_POS_Z: begin vx = a;  vy = -b; vz = h;  end
            FACE_NEG_Z: begin vx = -a; vy = -b; vz = -h; end
            default:    valid_face = 1'b0;
        endcase
        t.face = face;
        t.col  = col;
        t.row  = row;
        if (!valid_face) begin
            // unused face codes return black
            t.red   = '0;
            t.green = '0;
            t.blue  = '0;
        end else begin
            n       = vx * vx + vy * vy + vz * vz;
            t.red   = pack_channel(vx, n);
            t.green = pack_channel(vy, n);
            t.blue  = pack_channel(vz, n);
        end
        return t;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] texel mismatch: %s", $time, what);
        errors++;
    endtask

    task automatic compare_channel(input string name, input logic [CH_W-1:0] got,
                                   input logic [CH_W-1:0] want, input texel_t t);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d (face %0d col %0d row %0d)",
                                      name, got, want, t.face, t.col, t.row));
    endtask

    always @(posedge aclk) begin
        texel_t t;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                expected_texels.push_back(predict_texel(s_axis_tdata[2:0],
                                                        s_axis_tdata[7:3],
                                                        s_axis_tdata[12:8]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_texels.size() == 0) begin
                    report_mismatch($sformatf("unexpected texel %06h", m_axis_tdata));
                end else begin
                    t = expected_texels.pop_front();
                    compare_channel("red",   m_axis_tdata[7:0],   t.red,   t);
                    compare_channel("green", m_axis_tdata[15:8],  t.green, t);
                    compare_channel("blue",  m_axis_tdata[23:16], t.blue,  t);
                end
            end
        end
    end

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// Normalization cube map texel testbench
// Sends corner and out-of-range face requests, then random texel requests
// under changing source gaps and sink backpressure; the checker compares
// every returned texel.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ncm_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 232;      // per idling phase
    localparam int DRAIN_CYCLES = 40;       // pipeline is 19 deep

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    int fail_count;
    int texels_pending;
    int cycle_count = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;

    normalization_cube_map_texel dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ncm_texel_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .fail_count     (fail_count),
        .texels_pending (texels_pending)
    );

    initial begin
        forever #5ns aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // sink backpressure
    always @(posedge aclk) begin
        if (!aresetn)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_texel(input logic [FACE_W-1:0] face, input logic [COL_W-1:0] col,
                              input logic [ROW_W-1:0] row);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, row, col, face};
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
    endtask

    // hold the source off until every request has come back
    task automatic wait_all_returned();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (texels_pending != 0)
            @(posedge aclk);
    endtask

    task automatic run_phase(input int src_idle, input int sink_stall);
        idle_pct  = src_idle;
        stall_pct = sink_stall;
        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_texel(FACE_W'($urandom_range(7)), COL_W'($urandom_range(31)),
                       ROW_W'($urandom_range(31)));
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // face corners, all face codes including the unused ones
        for (int f = 0; f < 8; f++) begin
            send_texel(FACE_W'(f), COL_W'(0), ROW_W'(0));
            send_texel(FACE_W'(f), COL_W'(31), ROW_W'(31));
            send_texel(FACE_W'(f), COL_W'(0), ROW_W'(31));
        end
        send_texel(FACE_POS_Z, COL_W'(16), ROW_W'(15));
        wait_all_returned();

        run_phase(0, 0);
        run_phase(46, 0);
        wait_all_returned();
        run_phase(0, 46);
        run_phase(6, 6);

        wait_all_returned();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
